// File: rtl/core/lpmap_pkg.sv
`default_nettype none

package lpmap_pkg;

    localparam int INDEX_BITS = 10;
    localparam int SLOT_COUNT = 1 << INDEX_BITS;
    localparam int KEY_BITS   = 60;
    localparam int VAL_BITS   = 64;

    localparam logic [63:0] GOLDEN_MULT = 64'h9E3779B97F4A7C15;

    typedef logic [INDEX_BITS-1:0] idx_t;
    typedef logic [INDEX_BITS:0]   count_t;
    typedef logic [KEY_BITS-1:0]   key_t;
    typedef logic [VAL_BITS-1:0]   val_t;

    localparam count_t SLOT_COUNT_C = count_t'(SLOT_COUNT);
    localparam idx_t   SLOT_LAST    = idx_t'(SLOT_COUNT - 1);

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_POP    = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_ZERO_KEY  = 2'd3
    } status_t;

    // home slot rides along with the key so the shift walk needs no rehash
    typedef struct packed {
        key_t key;
        idx_t home;
        val_t addr;
        val_t size;
    } slot_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_SHIFT,
        S_SHEND,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/lpmap_if.sv
`default_nettype none

interface lpmap_req_if;
    logic                  valid;
    logic                  ready;
    lpmap_pkg::func_t      func;
    logic [59:0]           key;
    logic [63:0]           addr_in;
    logic [63:0]           size_in;

    modport source (output valid, output func, output key, output addr_in, output size_in,
                    input ready);
    modport sink   (input valid, input func, input key, input addr_in, input size_in,
                    output ready);
endinterface

interface lpmap_rsp_if;
    logic                  valid;
    logic                  ready;
    lpmap_pkg::status_t    status;
    logic [63:0]           addr_out;
    logic [63:0]           size_out;

    modport source (output valid, output status, output addr_out, output size_out,
                    input ready);
    modport sink   (input valid, input status, input addr_out, input size_out,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/core/linear_probe_map_backshift_delete.sv
// Flow: a zero key or an insert into a full map goes straight to the result beat;
// insert hashes, then probes slots; pop hashes, probes, then on a hit runs a shift walk.
// Throughput: one item at a time; hash runs on one 32x32 multiplier, then
// one slot per cycle through the single-port-read slot memory, pipelined with forwarding.
// Reset: asynchronous, active low; a clearing pass then writes every slot empty,
// with req.ready low, before the first item is taken.
`default_nettype none

module linear_probe_map_backshift_delete (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lpmap_req_if.sink   req,
    lpmap_rsp_if.source rsp
);

    localparam int IB = lpmap_pkg::INDEX_BITS;

    lpmap_pkg::state_t  state_reg, state_next;
    logic [1:0]         hash_cnt_reg, hash_cnt_next;
    logic [63:0]        prod_reg, prod_next;
    logic [63:0]        acc_reg, acc_next;
    lpmap_pkg::func_t   func_reg, func_next;
    lpmap_pkg::key_t    key_reg, key_next;
    lpmap_pkg::val_t    addr_reg, addr_next;
    lpmap_pkg::val_t    size_reg, size_next;
    lpmap_pkg::idx_t    home_reg, home_next;
    lpmap_pkg::idx_t    issue_idx_reg, issue_idx_next;
    lpmap_pkg::idx_t    data_idx_reg, data_idx_next;
    logic               rdv_reg, rdv_next;
    lpmap_pkg::idx_t    step_reg, step_next;
    lpmap_pkg::idx_t    hole_reg, hole_next;
    lpmap_pkg::count_t  count_reg, count_next;
    lpmap_pkg::idx_t    clr_reg, clr_next;
    lpmap_pkg::status_t res_status_reg, res_status_next;
    lpmap_pkg::val_t    res_addr_reg, res_addr_next;
    lpmap_pkg::val_t    res_size_reg, res_size_next;
    logic               ovalid_reg, ovalid_next;
    lpmap_pkg::status_t ostatus_reg, ostatus_next;
    lpmap_pkg::val_t    oaddr_reg, oaddr_next;
    lpmap_pkg::val_t    osize_reg, osize_next;
    logic               fwd_valid_reg, fwd_valid_next;
    lpmap_pkg::idx_t    fwd_addr_reg, fwd_addr_next;
    lpmap_pkg::slot_t   fwd_data_reg, fwd_data_next;

    logic               ram_we;
    lpmap_pkg::idx_t    ram_waddr;
    lpmap_pkg::slot_t   ram_wdata;
    lpmap_pkg::slot_t   ram_rdata;
    lpmap_pkg::slot_t   rd_slot;

    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_p;
    logic [63:0]        hash_sum;
    logic               move;

    lpmap_ram #(
        .WIDTH ($bits(lpmap_pkg::slot_t)),
        .DEPTH (lpmap_pkg::SLOT_COUNT)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (issue_idx_reg),
        .rdata (ram_rdata)
    );

    // key * golden mod 2^64 from three 32x32 partial products
    assign mul_a    = (hash_cnt_reg[1] == 1'b0) ? key_reg[31:0]
                                                : {4'b0, key_reg[59:32]};
    assign mul_b    = (hash_cnt_reg[0] == 1'b0) ? lpmap_pkg::GOLDEN_MULT[31:0]
                                                : lpmap_pkg::GOLDEN_MULT[63:32];
    assign mul_p    = mul_a * mul_b;
    assign hash_sum = acc_reg + {prod_reg[31:0], 32'b0};

    // forward the word written in the cycle the read was issued
    assign rd_slot = (fwd_valid_reg && (fwd_addr_reg == data_idx_reg)) ? fwd_data_reg
                                                                      : ram_rdata;

    always_comb
    begin
        if (hole_reg < data_idx_reg)
        begin
            move = (rd_slot.home <= hole_reg) || (rd_slot.home > data_idx_reg);
        end
        else
        begin
            move = (rd_slot.home <= hole_reg) && (rd_slot.home > data_idx_reg);
        end
    end

    assign req.ready    = (state_reg == lpmap_pkg::S_IDLE);
    assign rsp.valid    = ovalid_reg;
    assign rsp.status   = ostatus_reg;
    assign rsp.addr_out = oaddr_reg;
    assign rsp.size_out = osize_reg;

    always_comb
    begin
        state_next      = state_reg;
        hash_cnt_next   = hash_cnt_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        addr_next       = addr_reg;
        size_next       = size_reg;
        home_next       = home_reg;
        issue_idx_next  = issue_idx_reg;
        data_idx_next   = data_idx_reg;
        rdv_next        = rdv_reg;
        step_next       = step_reg;
        hole_next       = hole_reg;
        count_next      = count_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_size_next   = res_size_reg;
        ovalid_next     = ovalid_reg && !rsp.ready;
        ostatus_next    = ostatus_reg;
        oaddr_next      = oaddr_reg;
        osize_next      = osize_reg;
        ram_we          = 1'b0;
        ram_waddr       = hole_reg;
        ram_wdata       = rd_slot;

        unique case (state_reg)
            lpmap_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == lpmap_pkg::SLOT_LAST)
                begin
                    state_next = lpmap_pkg::S_IDLE;
                end
            end

            lpmap_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next     = req.func;
                    key_next      = req.key;
                    addr_next     = req.addr_in;
                    size_next     = req.size_in;
                    res_addr_next = '0;
                    res_size_next = '0;
                    hash_cnt_next = '0;
                    priority if (req.key == '0)
                    begin
                        res_status_next = lpmap_pkg::STAT_ZERO_KEY;
                        state_next      = lpmap_pkg::S_RESP;
                    end
                    else if ((req.func == lpmap_pkg::FUNC_INSERT) &&
                             (count_reg == lpmap_pkg::SLOT_COUNT_C))
                    begin
                        res_status_next = lpmap_pkg::STAT_FULL;
                        state_next      = lpmap_pkg::S_RESP;
                    end
                    else
                    begin
                        state_next = lpmap_pkg::S_HASH;
                    end
                end
            end

            lpmap_pkg::S_HASH:
            begin
                prod_next     = mul_p;
                hash_cnt_next = hash_cnt_reg + 1'b1;
                unique case (hash_cnt_reg)
                    2'd0:
                    begin
                    end
                    2'd1:
                    begin
                        acc_next = prod_reg;
                    end
                    2'd2:
                    begin
                        acc_next = hash_sum;
                    end
                    default:
                    begin
                        home_next      = hash_sum[63 -: IB];
                        issue_idx_next = hash_sum[63 -: IB];
                        rdv_next       = 1'b0;
                        step_next      = '0;
                        state_next     = lpmap_pkg::S_PROBE;
                    end
                endcase
            end

            lpmap_pkg::S_PROBE:
            begin
                issue_idx_next = issue_idx_reg + 1'b1;
                data_idx_next  = issue_idx_reg;
                rdv_next       = 1'b1;
                if (rdv_reg)
                begin
                    if (func_reg == lpmap_pkg::FUNC_INSERT)
                    begin
                        if (rd_slot.key == '0)
                        begin
                            ram_we          = 1'b1;
                            ram_waddr       = data_idx_reg;
                            ram_wdata       = '{key: key_reg, home: home_reg,
                                                addr: addr_reg, size: size_reg};
                            count_next      = count_reg + 1'b1;
                            res_status_next = lpmap_pkg::STAT_OK;
                            state_next      = lpmap_pkg::S_RESP;
                        end
                    end
                    else
                    begin
                        priority if (rd_slot.key == key_reg)
                        begin
                            // next slot read is already in flight: walk on from here
                            res_addr_next = rd_slot.addr;
                            res_size_next = rd_slot.size;
                            hole_next     = data_idx_reg;
                            step_next     = '0;
                            state_next    = lpmap_pkg::S_SHIFT;
                        end
                        else if ((rd_slot.key == '0) || (step_reg == lpmap_pkg::SLOT_LAST))
                        begin
                            res_status_next = lpmap_pkg::STAT_NOT_FOUND;
                            state_next      = lpmap_pkg::S_RESP;
                        end
                        else
                        begin
                            step_next = step_reg + 1'b1;
                        end
                    end
                end
            end

            lpmap_pkg::S_SHIFT:
            begin
                issue_idx_next = issue_idx_reg + 1'b1;
                data_idx_next  = issue_idx_reg;
                rdv_next       = 1'b1;
                // the hole is still stale in memory: a wrap onto it reads as empty
                if ((rd_slot.key == '0) || (data_idx_reg == hole_reg))
                begin
                    state_next = lpmap_pkg::S_SHEND;
                end
                else
                begin
                    if (move)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = hole_reg;
                        ram_wdata = rd_slot;
                        hole_next = data_idx_reg;
                    end
                    if (step_reg == lpmap_pkg::SLOT_LAST)
                    begin
                        state_next = lpmap_pkg::S_SHEND;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end

            lpmap_pkg::S_SHEND:
            begin
                ram_we          = 1'b1;
                ram_waddr       = hole_reg;
                ram_wdata       = '0;
                count_next      = count_reg - 1'b1;
                res_status_next = lpmap_pkg::STAT_OK;
                state_next      = lpmap_pkg::S_RESP;
            end

            lpmap_pkg::S_RESP:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next  = 1'b1;
                    ostatus_next = res_status_reg;
                    oaddr_next   = res_addr_reg;
                    osize_next   = res_size_reg;
                    state_next   = lpmap_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = lpmap_pkg::S_IDLE;
            end
        endcase

        fwd_valid_next = ram_we;
        fwd_addr_next  = ram_waddr;
        fwd_data_next  = ram_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpmap_pkg::S_CLEAR;
            hash_cnt_reg  <= '0;
            rdv_reg       <= 1'b0;
            step_reg      <= '0;
            count_reg     <= '0;
            clr_reg       <= '0;
            ovalid_reg    <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_cnt_reg  <= hash_cnt_next;
            rdv_reg       <= rdv_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            clr_reg       <= clr_next;
            ovalid_reg    <= ovalid_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        func_reg       <= func_next;
        key_reg        <= key_next;
        addr_reg       <= addr_next;
        size_reg       <= size_next;
        home_reg       <= home_next;
        issue_idx_reg  <= issue_idx_next;
        data_idx_reg   <= data_idx_next;
        hole_reg       <= hole_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_size_reg   <= res_size_next;
        ostatus_reg    <= ostatus_next;
        oaddr_reg      <= oaddr_next;
        osize_reg      <= osize_next;
        fwd_addr_reg   <= fwd_addr_next;
        fwd_data_reg   <= fwd_data_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= lpmap_pkg::SLOT_COUNT_C)
        else $error("occupied count above slot count");

    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpmap_pkg::S_PROBE && ram_we) |=>
        (count_reg == $past(count_reg) + 1'b1))
        else $error("insert write without count increment");

    a_shift_no_self_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpmap_pkg::S_SHIFT && ram_we) |-> (ram_waddr != data_idx_reg))
        else $error("shift move writes the slot it reads");

    a_miss_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != lpmap_pkg::STAT_OK) |->
        (rsp.addr_out == '0 && rsp.size_out == '0))
        else $error("nonzero payload on a failed beat");

endmodule

`default_nettype wire

// File: rtl/core/lpmap_ram.sv
`default_nettype none

module lpmap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
